[hw/rtl/ckf_pkg.sv]
// Shared types and constants for the coalescing key FIFO.
// No dependencies; imported by every RTL file of the block.
package ckf_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths on the stream ports.
    localparam int KEY_FIELD_W    = 16;
    localparam int VALUE_FIELD_W  = 32;
    localparam int COUNT_FIELD_W  = 5;
    localparam int STATUS_FIELD_W = 3;
    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 56;
    localparam int OUT_PAD_W      = OUT_DATA_W - KEY_FIELD_W - VALUE_FIELD_W - COUNT_FIELD_W;

    typedef enum logic [0:0] {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } ckf_cmd_t;

    typedef enum logic [STATUS_FIELD_W-1:0] {
        ST_APPENDED  = 3'd0,
        ST_COALESCED = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_POPPED    = 3'd3,
        ST_EMPTY     = 3'd4
    } ckf_status_t;

    // Contents of one cell.
    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } ckf_entry_t;

    // Operation broadcast to the row for one accepted request.
    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic                  append;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } ckf_op_t;

endpackage

[hw/rtl/coalescing_key_fifo_top.sv]
// Top level of the coalescing key FIFO: stream ports, result register, count.
// Depends on ckf_pkg and ckf_chain.
//
//   channel | dir | tdata (low bit up)                       | tuser
//   --------+-----+------------------------------------------+----------------
//   s_*     | in  | item_key[15:0], item_value[31:0]         | cmd (0 push, 1 pop)
//   m_*     | out | out_key[15:0], out_value[31:0],          | status[2:0]
//           |     | pending_count[4:0], 3 zero bits          |
//
// Cycles: one request per clock while s_tready is high. All cells compare the key in the same cycle
// and the whole row shifts or writes at the accepting edge, which also loads the
// result into the output register.
// Stalls: s_tready drops only while a result waits in the output register and
// m_tready is low; a result taken in the same cycle frees the slot at once.
// Reset: every cell empty, no result pending; cell keys and values stay unset.
module coalescing_key_fifo_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ckf_pkg::IN_DATA_W-1:0]     s_tdata,  // item_key, item_value
    input  logic [0:0]                        s_tuser,  // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ckf_pkg::OUT_DATA_W-1:0]    m_tdata,  // out_key, out_value, pending_count
    output logic [ckf_pkg::STATUS_FIELD_W-1:0] m_tuser  // status
);
    import ckf_pkg::*;

    logic                       accept;
    logic                       is_push;
    logic                       is_pop;
    logic [KEY_BITS-1:0]        in_key;
    logic [VALUE_BITS-1:0]      in_value;
    ckf_entry_t                 head;
    logic                       hit_any;
    logic                       full;

    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    ckf_status_t                status_reg;
    ckf_status_t                status_next;
    logic [KEY_FIELD_W-1:0]     okey_reg;
    logic [KEY_FIELD_W-1:0]     okey_next;
    logic [VALUE_FIELD_W-1:0]   oval_reg;
    logic [VALUE_FIELD_W-1:0]   oval_next;
    logic [COUNT_FIELD_W-1:0]   ocount_reg;

    // Take a new request whenever the result slot is free or draining.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign in_key   = s_tdata[KEY_BITS-1:0];
    assign in_value = s_tdata[KEY_FIELD_W +: VALUE_BITS];

    // Pop on an empty row leaves the cells alone.
    assign is_push  = accept && (ckf_cmd_t'(s_tuser[0]) == CMD_PUSH);
    assign is_pop   = accept && (ckf_cmd_t'(s_tuser[0]) == CMD_POP) && (count_reg != '0);

    ckf_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (is_push),
        .pop     (is_pop),
        .key     (in_key),
        .value   (in_value),
        .head    (head),
        .hit_any (hit_any),
        .full    (full)
    );

    // Classify the request and build the result.
    always_comb
    begin
        status_next = ST_APPENDED;
        okey_next   = '0;
        oval_next   = '0;
        count_next  = count_reg;
        if (ckf_cmd_t'(s_tuser[0]) == CMD_PUSH)
        begin
            if (hit_any)
            begin
                status_next = ST_COALESCED;
            end
            else if (full)
            begin
                status_next = ST_DROPPED;
            end
            else
            begin
                status_next = ST_APPENDED;
                count_next  = count_reg + CNT_W'(1);
            end
        end
        else if (count_reg == '0)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next = ST_POPPED;
            okey_next   = KEY_FIELD_W'(head.key);
            oval_next   = VALUE_FIELD_W'(head.value);
            count_next  = count_reg - CNT_W'(1);
        end
    end

    // Hold the result until taken; a new request refills the slot.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            okey_reg   <= okey_next;
            oval_reg   <= oval_next;
            ocount_reg <= COUNT_FIELD_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, ocount_reg, oval_reg, okey_reg};

endmodule

[hw/rtl/ckf_cell.sv]
// One storage cell of the key row: holds a key, a value and an occupancy bit.
// Depends on ckf_pkg.
module ckf_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ckf_pkg::ckf_op_t   op,
    input  ckf_pkg::ckf_entry_t upper,      // neighbor toward the tail
    input  logic               lower_valid, // neighbor toward the head is occupied
    output ckf_pkg::ckf_entry_t entry,
    output logic               hit
);
    import ckf_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  append_here;

    assign hit         = valid_reg && (key_reg == op.key);
    assign append_here = op.append && !valid_reg && lower_valid;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (op.pop)
        begin
            // shift toward the head
            valid_next = upper.valid;
            key_next   = upper.key;
            value_next = upper.value;
        end
        else if (append_here)
        begin
            valid_next = 1'b1;
            key_next   = op.key;
            value_next = op.value;
        end
        else if (op.push && hit)
        begin
            value_next = op.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule

[hw/rtl/ckf_chain.sv]
// Row of DEPTH cells, head at cell 0; merges the per-cell match flags.
// Depends on ckf_pkg and ckf_cell.
module ckf_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                pop,
    input  logic [ckf_pkg::KEY_BITS-1:0]   key,
    input  logic [ckf_pkg::VALUE_BITS-1:0] value,
    output ckf_pkg::ckf_entry_t head,
    output logic                hit_any,
    output logic                full
);
    import ckf_pkg::*;

    ckf_entry_t             cells [DEPTH];
    ckf_entry_t             uppers [DEPTH];
    logic [DEPTH-1:0]       lower_valid;
    logic [DEPTH-1:0]       hits;
    ckf_op_t                op;

    assign hit_any = |hits;
    assign full    = cells[DEPTH-1].valid;

    always_comb
    begin
        op.push   = push;
        op.pop    = pop;
        op.append = push && !hit_any && !full;
        op.key    = key;
        op.value  = value;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == DEPTH - 1)
            begin : g_tail
                assign uppers[i] = '0;
            end
            else
            begin : g_mid
                assign uppers[i] = cells[i+1];
            end

            if (i == 0)
            begin : g_head
                assign lower_valid[i] = 1'b1;
            end
            else
            begin : g_rest
                assign lower_valid[i] = cells[i-1].valid;
            end

            ckf_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .upper       (uppers[i]),
                .lower_valid (lower_valid[i]),
                .entry       (cells[i]),
                .hit         (hits[i])
            );
        end
    endgenerate

    assign head = cells[0];

endmodule

[hw/rtl/ckf_checker.sv]
// Port-level checks for the coalescing key FIFO, bound to the top level.
// Depends on ckf_pkg.
module ckf_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [ckf_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic [ckf_pkg::STATUS_FIELD_W-1:0] m_tuser
);
    import ckf_pkg::*;

    localparam int CNT_LSB = KEY_FIELD_W + VALUE_FIELD_W;

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only a pop returns a key and value.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_POPPED) |-> m_tdata[CNT_LSB-1:0] == '0)
        else $error("payload nonzero on a non-pop result");

    // A drop happens only when the row is full.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_DROPPED)
        |-> m_tdata[CNT_LSB +: COUNT_FIELD_W] == COUNT_FIELD_W'(DEPTH))
        else $error("drop reported below full");

    // Empty pop reports zero pending keys.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_EMPTY) |-> m_tdata[CNT_LSB +: COUNT_FIELD_W] == '0)
        else $error("empty pop with keys pending");

    // Accepted request with the slot free shows a result next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted request");

endmodule

bind coalescing_key_fifo_top ckf_checker u_ckf_checker (.*);

[tb/sv/coalescing_key_fifo_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the coalescing key FIFO top level.
// Depends on ckf_pkg and coalescing_key_fifo_top; the predictor and stimulus are local.
module coalescing_key_fifo_top_tb;

    import ckf_pkg::*;

    // One request as offered on the slave side; drain_first holds it back
    // until every outstanding result has come out.
    typedef struct {
        ckf_cmd_t          cmd;
        logic [15:0]       key;
        logic [31:0]       value;
        bit                drain_first;
    } request_t;

    // One result as it should leave the master side.
    typedef struct {
        ckf_status_t       status;
        logic [15:0]       key;
        logic [31:0]       value;
        logic [4:0]        count;
    } outcome_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // item_key, item_value
    logic [0:0]            s_tuser   = CMD_PUSH;  // cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // out_key, out_value, pending_count
    logic [STATUS_FIELD_W-1:0] m_tuser;      // status

    // Requests waiting to be driven, and results owed by the block.
    request_t              stim_q[$];
    outcome_t              due_outcomes[$];

    // Predicted queue contents, oldest entry at index 0.
    logic [15:0]           line_key[DEPTH];
    logic [31:0]           line_value[DEPTH];
    int                    line_len = 0;

    bit                    req_taken = 0;     // request accepted at the last rising edge
    int                    requests_taken = 0;
    int                    results_seen = 0;
    int                    fail_cnt = 0;
    int                    status_seen[5] = '{0, 0, 0, 0, 0};
    int                    hold_left = 0;
    int                    hold_idx = 0;
    int                    hold_mark[2] = '{400, 800};
    logic [15:0]           key_pool[24];

    coalescing_key_fifo_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Advance the predicted queue by one request and return the result it owes.
    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        int       hit;
        o.status = ST_APPENDED;
        o.key    = '0;
        o.value  = '0;
        hit      = -1;
        if (r.cmd == CMD_PUSH)
        begin
            for (int i = 0; i < line_len; i++)
            begin
                if (line_key[i] == r.key)
                    hit = i;
            end
            if (hit >= 0)
            begin
                // Known key: overwrite the value, keep its place in line.
                line_value[hit] = r.value;
                o.status = ST_COALESCED;
            end
            else if (line_len >= DEPTH)
            begin
                o.status = ST_DROPPED;
            end
            else
            begin
                line_key[line_len]   = r.key;
                line_value[line_len] = r.value;
                line_len++;
            end
        end
        else if (line_len == 0)
        begin
            o.status = ST_EMPTY;
        end
        else
        begin
            o.status = ST_POPPED;
            o.key    = line_key[0];
            o.value  = line_value[0];
            for (int i = 0; i + 1 < line_len; i++)
            begin
                line_key[i]   = line_key[i + 1];
                line_value[i] = line_value[i + 1];
            end
            line_len--;
        end
        o.count = line_len[4:0];
        return o;
    endfunction

    // Idle pattern, cycling every hundred accepted requests:
    // none, sender idle 60%, receiver stall 60%, both 29%.
    function automatic int idle_mode();
        return (requests_taken / 100) % 4;
    endfunction

    task automatic add_request(ckf_cmd_t cmd, logic [15:0] key, logic [31:0] value,
                               bit drain_first);
        request_t r;
        r.cmd         = cmd;
        r.key         = key;
        r.value       = value;
        r.drain_first = drain_first;
        stim_q.insert(stim_q.size(), r);
    endtask

    // Driver: hold a request until taken, then load the next one or idle.
    always @(negedge clk)
    begin : drive_requests
        request_t r;
        bit       next_valid;
        int       idle_pct;
        if (rst_n && !(s_tvalid && !req_taken))
        begin
            next_valid = 1'b0;
            idle_pct   = (idle_mode() == 1) ? 60 : (idle_mode() == 3) ? 29 : 0;
            if (stim_q.size() != 0
                && !(stim_q[0].drain_first && due_outcomes.size() != 0)
                && $urandom_range(0, 99) >= idle_pct)
            begin
                r = stim_q[0];
                stim_q.delete(0);
                s_tdata    <= {r.value, r.key};
                s_tuser    <= r.cmd;
                next_valid = 1'b1;
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: random stalls per phase, plus long hold-offs counted here so the
    // sender keeps offering requests into a stalled block.
    always @(negedge clk)
    begin : drive_ready
        int stall_pct;
        stall_pct = (idle_mode() == 2) ? 60 : (idle_mode() == 3) ? 29 : 0;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_idx < 2 && requests_taken >= hold_mark[hold_idx])
        begin
            hold_left = 120;
            hold_idx++;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: check the result leaving this edge, then predict for the request
    // entering it. The result of a request never leaves on its own accepting edge.
    always @(posedge clk)
    begin : watch_ports
        request_t r;
        outcome_t want;
        req_taken = 0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tuser < 5)
                    status_seen[m_tuser]++;
                if (due_outcomes.size() == 0)
                begin
                    $error("unexpected result: status %0d key %0h value %0h count %0d",
                           m_tuser, m_tdata[15:0], m_tdata[47:16], m_tdata[52:48]);
                    fail_cnt++;
                end
                else
                begin
                    want = due_outcomes[0];
                    due_outcomes.delete(0);
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata[15:0] !== want.key)
                    begin
                        $error("out_key: expected %0h, got %0h", want.key, m_tdata[15:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[47:16] !== want.value)
                    begin
                        $error("out_value: expected %0h, got %0h", want.value,
                               m_tdata[47:16]);
                        fail_cnt++;
                    end
                    if (m_tdata[52:48] !== want.count)
                    begin
                        $error("pending_count: expected %0d, got %0d", want.count,
                               m_tdata[52:48]);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                r.cmd         = ckf_cmd_t'(s_tuser);
                r.key         = s_tdata[15:0];
                r.value       = s_tdata[47:16];
                r.drain_first = 1'b0;
                due_outcomes.insert(due_outcomes.size(), apply_request(r));
                req_taken = 1;
                requests_taken++;
            end
        end
    end

    // Stimulus, reset and final verdict.
    initial
    begin : run_test
        int push_pct;
        logic [15:0] k;
        // Directed: empty pop, extreme keys and values, coalesce, then fill to
        // DEPTH and probe a dropped new key and a coalesce while full.
        add_request(CMD_POP,  16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        add_request(CMD_PUSH, 16'h0000, 32'h0000_0000, 1'b0);
        add_request(CMD_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        add_request(CMD_PUSH, 16'h0000, 32'h5A5A_A5A5, 1'b0);
        add_request(CMD_POP,  16'h0000, 32'h0000_0000, 1'b0);
        add_request(CMD_POP,  16'h1234, 32'h8765_4321, 1'b0);
        add_request(CMD_POP,  16'h0000, 32'h0000_0000, 1'b0);
        for (int i = 0; i < DEPTH; i++)
            add_request(CMD_PUSH, 16'h1000 + 16'(i), $urandom, 1'b0);
        add_request(CMD_PUSH, 16'hBEEF, $urandom, 1'b0);
        add_request(CMD_PUSH, 16'h1007, 32'hC0FF_EE00, 1'b0);

        // Random: mostly keys from a small pool (larger than DEPTH) so pushes
        // coalesce and the queue reaches full; push bias changes every 50 requests
        // to swing between full and empty.
        foreach (key_pool[i])
            key_pool[i] = $urandom_range(0, 65535);
        push_pct = 50;
        for (int n = 0; n < 880; n++)
        begin
            if (n % 50 == 0)
                push_pct = ($urandom_range(0, 2) == 0) ? 25 :
                           ($urandom_range(0, 1) == 0) ? 50 : 80;
            k = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 23)]
                                            : 16'($urandom_range(0, 65535));
            add_request(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
                        k, $urandom, (n == 300 || n == 650));
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid || due_outcomes.size() != 0)
            @(posedge clk);
        // Catch any stray result after the last expected one.
        repeat (20) @(posedge clk);

        $display("Run: %0d requests, %0d results (appended %0d, coalesced %0d, dropped %0d,",
                 requests_taken, results_seen, status_seen[0], status_seen[1],
                 status_seen[2]);
        $display("     popped %0d, empty pops %0d), with idle phases and long stalls",
                 status_seen[3], status_seen[4]);
        if (fail_cnt == 0)
        begin
            $display("coalescing_key_fifo_top_tb passed");
        end
        else
        begin
            $display("coalescing_key_fifo_top_tb failed");
        end
        $finish;
    end

    // Watchdog: stops a hung run and reports it as failed.
    initial
    begin : watchdog
        #200000;
        $display("coalescing_key_fifo_top_tb failed");
        $finish;
    end

endmodule

[coalescing_key_fifo_top.f]
hw/rtl/ckf_pkg.sv
hw/rtl/ckf_cell.sv
hw/rtl/ckf_chain.sv
hw/rtl/coalescing_key_fifo_top.sv
hw/rtl/ckf_checker.sv
tb/sv/coalescing_key_fifo_top_tb.sv
